/* rtl/dsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the subsequence counter
// Character width, result width, operation codes, result flag positions and
// the control word that is broadcast along the row of cells.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int CH_W        = 8;
  localparam int OUT_COUNT_W = 64;

  // Operation codes carried in the input tuser bit.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Bit positions of the flags in the output tuser field.
  localparam int USER_SAT_BIT = 0;
  localparam int USER_REJ_BIT = 1;
  localparam int OUT_USER_W   = 2;

  // Control word shared by every cell for the word being accepted.
  typedef struct packed {
    logic            load;  // append a pattern character (pattern not full)
    logic            text;  // process a text character
    logic [CH_W-1:0] ch;
  } dsc_ctl_t;

endpackage
`default_nettype wire

/* rtl/dsc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_cell: one pattern position of the counter row
// Holds one pattern character, its valid bit and the saturating count of the
// prefix that ends at this character.
// ----------------------------------------------------------------------------
module dsc_cell #(
  parameter int COUNT_WIDTH = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  dsc_pkg::dsc_ctl_t    ctl,
  // Character and valid bit of the neighbor that holds a later pattern
  // position; they move one cell deeper on a load.
  input  wire  [dsc_pkg::CH_W-1:0]   shift_char_i,
  input  wire                        shift_valid_i,
  // Count of the shorter prefix, held by the neighbor on the other side.
  input  wire  [COUNT_WIDTH-1:0]     pred_count_i,
  input  wire                        pred_valid_i,
  output logic [dsc_pkg::CH_W-1:0]   char_o,
  output logic                       valid_o,
  output logic [COUNT_WIDTH-1:0]     count_o,
  output logic [COUNT_WIDTH-1:0]     count_nxt_o
);
  import dsc_pkg::*;

  logic [CH_W-1:0]        char_r;
  logic                   valid_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] pred;
  logic [COUNT_WIDTH:0]   sum;

  // A missing predecessor stands for the empty prefix, whose count is one.
  assign pred = pred_valid_i ? pred_count_i : COUNT_WIDTH'(1);
  assign sum  = {1'b0, count_r} + {1'b0, pred};

  always_comb begin
    count_nxt = count_r;
    if (ctl.load) begin
      count_nxt = '0;
    end else if (ctl.text && valid_r && (char_r == ctl.ch)) begin
      count_nxt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (ctl.load) begin
        valid_r <= shift_valid_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      char_r <= shift_char_i;
    end
  end

  assign char_o      = char_r;
  assign valid_o     = valid_r;
  assign count_o     = count_r;
  assign count_nxt_o = count_nxt;

endmodule
`default_nettype wire

/* rtl/distinct_subsequence_counter.sv */
// A result word is in the output register in the cycle after its input word
// is accepted. Throughput: one word per cycle while out_tready is high;
// every cell of the row updates in the same cycle, so pattern length does not
// change the rate. Reset (synchronous, rst_n low) empties the pattern, clears
// all counts and drops out_tvalid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_subsequence_counter: streaming subsequence occurrence counter
// Counts how often a loaded pattern occurs as a subsequence of the text
// streamed so far, with saturating counters held in a row of cells.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter #(
  parameter int MAX_PATTERN = 128,
  parameter int COUNT_WIDTH = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [dsc_pkg::CH_W-1:0]          in_tdata,   // [7:0] ch
  input  wire                               in_tuser,   // [0] op
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [dsc_pkg::OUT_COUNT_W-1:0]   out_tdata,  // [63:0] count
  output logic [dsc_pkg::OUT_USER_W-1:0]    out_tuser   // [0] saturated,
                                                        // [1] load_rejected
);
  import dsc_pkg::*;

  // The pattern is stored last character first: cell 0 always holds the final
  // pattern position, so the whole-pattern count sits at a fixed place. A load
  // shifts every character one cell deeper and puts the new one into cell 0.
  // The count of a cell's shorter prefix comes from the next deeper cell; the
  // first empty cell stands for the empty prefix, whose count is one.

  logic [CH_W-1:0]        cell_char  [MAX_PATTERN];
  logic                   cell_valid [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0] cell_count [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0] cell_nxt   [MAX_PATTERN];

  dsc_ctl_t               ctl;
  logic                   accept;
  logic                   full;
  logic                   rejected;
  logic [COUNT_WIDTH-1:0] total;

  logic                   out_valid_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_sat_r;
  logic                   out_rej_r;

  // The output register parts the two sides: a new word is taken whenever the
  // register is empty or its word is taken in the same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // The pattern is full when the deepest cell is occupied.
  assign full     = cell_valid[MAX_PATTERN-1];
  assign rejected = accept && (in_tuser == OP_LOAD) && full;

  assign ctl.load = accept && (in_tuser == OP_LOAD) && !full;
  assign ctl.text = accept && (in_tuser == OP_TEXT);
  assign ctl.ch   = in_tdata;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [CH_W-1:0]        shift_char;
    logic                   shift_valid;
    logic [COUNT_WIDTH-1:0] pred_count;
    logic                   pred_valid;

    if (k == 0) begin : g_head
      assign shift_char  = in_tdata;
      assign shift_valid = 1'b1;
    end else begin : g_body
      assign shift_char  = cell_char[k-1];
      assign shift_valid = cell_valid[k-1];
    end

    if (k == MAX_PATTERN - 1) begin : g_tail
      assign pred_count = '0;
      assign pred_valid = 1'b0;
    end else begin : g_link
      assign pred_count = cell_count[k+1];
      assign pred_valid = cell_valid[k+1];
    end

    dsc_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .shift_char_i (shift_char),
      .shift_valid_i(shift_valid),
      .pred_count_i (pred_count),
      .pred_valid_i (pred_valid),
      .char_o       (cell_char[k]),
      .valid_o      (cell_valid[k]),
      .count_o      (cell_count[k]),
      .count_nxt_o  (cell_nxt[k])
    );
  end

  // The result reflects the state after this word. With an empty pattern the
  // count is that of the empty prefix, which is one.
  assign total = (ctl.load || cell_valid[0]) ? cell_nxt[0] : COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_count_r <= OUT_COUNT_W'(total);
      out_sat_r   <= (total == '1);
      out_rej_r   <= rejected;
    end
  end

  assign out_tvalid               = out_valid_r;
  assign out_tdata                = out_count_r;
  assign out_tuser[USER_SAT_BIT]  = out_sat_r;
  assign out_tuser[USER_REJ_BIT]  = out_rej_r;

endmodule
`default_nettype wire

/* rtl/dsc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_checker: port-level checks of the subsequence counter
// Watches the stream ports and checks result timing and flag consistency.
// ----------------------------------------------------------------------------
module dsc_checker #(
  parameter int COUNT_WIDTH = 64
) (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tvalid,
  input wire                               in_tready,
  input wire                               in_tuser,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [dsc_pkg::OUT_COUNT_W-1:0]    out_tdata,
  input wire [dsc_pkg::OUT_USER_W-1:0]     out_tuser
);
  import dsc_pkg::*;

  localparam logic [OUT_COUNT_W-1:0] SatValue = OUT_COUNT_W'({COUNT_WIDTH{1'b1}});

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Every accepted word gives a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("no result after an accepted word");

  // Only a load can be rejected.
  a_rej_text: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == OP_TEXT) |=> !out_tuser[USER_REJ_BIT])
    else $error("text word flagged as rejected load");

  // A load that is accepted and not rejected clears the whole-pattern count.
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == OP_LOAD) |=> out_tuser[USER_REJ_BIT] || (out_tdata == '0))
    else $error("accepted load did not clear the count");

  // The saturation flag matches the count.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[USER_SAT_BIT] == (out_tdata == SatValue)))
    else $error("saturation flag does not match count");

endmodule

bind distinct_subsequence_counter dsc_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_dsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for distinct_subsequence_counter
// Streams pattern loads and text characters into the counter and predicts
// every result word with a local model of the prefix counts. The stimulus
// runs in stages: directed corner cases, short embedded patterns, a long run
// that saturates the count, and a final fill of the pattern past its capacity.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_PAT     = 128;
  localparam int CNT_W       = 64;
  localparam int IDLE_PCT    = 29;
  localparam int CALM_LO     = 200;    // no idling on either side in this window
  localparam int CALM_HI     = 320;
  localparam int HOLD_AT     = 500;    // receiver blocks once after this many results
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic                     op;
    logic [dsc_pkg::CH_W-1:0] ch;
  } stream_word_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             saturated;
    logic             rejected;
  } tally_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [dsc_pkg::CH_W-1:0]          in_tdata   = '0;
  logic                              in_tuser   = dsc_pkg::OP_LOAD;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [dsc_pkg::OUT_COUNT_W-1:0]   out_tdata;
  logic [dsc_pkg::OUT_USER_W-1:0]    out_tuser;

  stream_word_t pending_words[$];
  tally_t       expected_tallies[$];

  // Local copy of the counter state.
  logic [7:0]       pat_mem [MAX_PAT];
  int               pat_len;
  logic [CNT_W-1:0] pfx_cnt [MAX_PAT+1];

  // Pattern as the stimulus generator knows it, used to build matching text.
  logic [7:0] gen_pattern [MAX_PAT];
  int         gen_len;

  int unsigned sent_words   = 0;
  int unsigned rcvd_words   = 0;
  int unsigned failures     = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  distinct_subsequence_counter #(
    .MAX_PATTERN (MAX_PAT),
    .COUNT_WIDTH (CNT_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  task automatic clear_prefix_counts();
    int j;
    pfx_cnt[0] = CNT_W'(1);
    for (j = 1; j <= MAX_PAT; j++) pfx_cnt[j] = '0;
  endtask

  task automatic predict_tally(input logic op, input logic [7:0] ch);
    tally_t t;
    int     j;
    t.rejected = 1'b0;
    if (op == dsc_pkg::OP_LOAD) begin
      if (pat_len < MAX_PAT) begin
        pat_mem[pat_len] = ch;
        pat_len++;
        clear_prefix_counts();
      end else begin
        t.rejected = 1'b1;
      end
    end else begin
      // Walk downward so every position adds the count held before this char.
      for (j = pat_len; j >= 1; j--) begin
        if (pat_mem[j-1] == ch) pfx_cnt[j] = sat_sum(pfx_cnt[j], pfx_cnt[j-1]);
      end
    end
    t.count     = pfx_cnt[pat_len];
    t.saturated = &t.count;
    expected_tallies = {expected_tallies, t};
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic queue_word(input logic op, input logic [7:0] ch);
    stream_word_t w;
    w.op = op;
    w.ch = ch;
    pending_words = {pending_words, w};
    if (op == dsc_pkg::OP_LOAD && gen_len < MAX_PAT) begin
      gen_pattern[gen_len] = ch;
      gen_len++;
    end
  endtask

  function automatic logic [7:0] abc_char();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  // Text that holds the first upto pattern characters in order, with some
  // random bytes mixed in.
  task automatic queue_prefix_text(input int upto, input int noise_pct);
    int i;
    for (i = 0; i < upto; i++) begin
      if ($urandom_range(0, 99) < noise_pct) queue_word(dsc_pkg::OP_TEXT, 8'($urandom));
      queue_word(dsc_pkg::OP_TEXT, gen_pattern[i]);
    end
  endtask

  initial begin
    int         n_load;
    int         txt_len;
    int         ptr;
    int         base;
    int         i;
    int         r;
    logic [7:0] x;

    pat_len = 0;
    gen_len = 0;
    clear_prefix_counts();

    // Directed: empty pattern, extreme bytes, text shorter than the pattern.
    queue_word(dsc_pkg::OP_TEXT, 8'h00);
    queue_word(dsc_pkg::OP_TEXT, 8'hFF);
    queue_word(dsc_pkg::OP_LOAD, 8'h00);
    queue_word(dsc_pkg::OP_TEXT, 8'h00);
    queue_word(dsc_pkg::OP_TEXT, 8'hFF);
    queue_word(dsc_pkg::OP_TEXT, 8'h00);
    queue_word(dsc_pkg::OP_LOAD, 8'hFF);
    queue_word(dsc_pkg::OP_TEXT, 8'hFF);
    queue_word(dsc_pkg::OP_TEXT, 8'h00);
    queue_word(dsc_pkg::OP_TEXT, 8'hFF);
    queue_word(dsc_pkg::OP_TEXT, 8'h00);
    queue_word(dsc_pkg::OP_TEXT, 8'hFF);

    // Short patterns over a small alphabet, with text woven from the pattern.
    ptr = 0;
    while (pending_words.size() < 390) begin
      n_load = (gen_len >= 16) ? 0 : $urandom_range(0, 2);
      for (i = 0; i < n_load; i++) begin
        queue_word(dsc_pkg::OP_LOAD,
                   ($urandom_range(0, 99) < 85) ? abc_char() : 8'($urandom));
      end
      if (n_load > 0) ptr = 0;
      txt_len = $urandom_range(3, 30);
      for (i = 0; i < txt_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          queue_word(dsc_pkg::OP_TEXT, gen_pattern[ptr]);
          ptr = (ptr + 1) % gen_len;
        end else if (r < 90) begin
          queue_word(dsc_pkg::OP_TEXT, abc_char());
        end else begin
          queue_word(dsc_pkg::OP_TEXT, 8'($urandom));
        end
      end
    end

    // A long run of one character drives the count into saturation.
    x    = 8'($urandom);
    base = gen_len;
    n_load = $urandom_range(30, 38);
    for (i = 0; i < n_load; i++) queue_word(dsc_pkg::OP_LOAD, x);
    queue_prefix_text(base, 10);
    for (i = 0; i < 80; i++) begin
      if ($urandom_range(0, 99) < 5) queue_word(dsc_pkg::OP_TEXT, 8'($urandom));
      queue_word(dsc_pkg::OP_TEXT, x);
    end

    // Fill the pattern to capacity, then try to load more while text runs.
    x    = 8'($urandom);
    base = gen_len;
    while (gen_len < MAX_PAT) queue_word(dsc_pkg::OP_LOAD, x);
    for (i = 0; i < 3; i++) queue_word(dsc_pkg::OP_LOAD, 8'($urandom));
    queue_prefix_text(base, 5);
    txt_len = (MAX_PAT - base) + $urandom_range(6, 14);
    for (i = 0; i < txt_len; i++) begin
      if ($urandom_range(0, 99) < 4) queue_word(dsc_pkg::OP_LOAD, 8'($urandom));
      queue_word(dsc_pkg::OP_TEXT, x);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so the queues are settled.
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_tallies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("distinct_subsequence_counter test passed");
    end else begin
      $display("distinct_subsequence_counter test failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // Driver: offers the next pending word, idling at random.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    stream_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_words.size() != 0 &&
          ((sent_words >= CALM_LO && sent_words < CALM_HI) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt        = pending_words.pop_front();
        in_tvalid  <= 1'b1;
        in_tuser   <= nxt.op;
        in_tdata   <= nxt.ch;
        sent_words <= sent_words + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver ready: random stalls, plus one long hold-off that backs up the
  // block while the driver keeps offering words.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && rcvd_words >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= (rcvd_words >= CALM_LO && rcvd_words < CALM_HI) ||
                    ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: checks each result word, then predicts for each accepted input.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    tally_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rcvd_words <= rcvd_words + 1;
        if (expected_tallies.size() == 0) begin
          $error("result word with nothing pending: count %0d", out_tdata);
          failures++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_tdata !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, out_tdata);
            failures++;
          end
          if (out_tuser[dsc_pkg::USER_SAT_BIT] !== want.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b",
                   want.saturated, out_tuser[dsc_pkg::USER_SAT_BIT]);
            failures++;
          end
          if (out_tuser[dsc_pkg::USER_REJ_BIT] !== want.rejected) begin
            $error("load_rejected mismatch: expected %0b, actual %0b",
                   want.rejected, out_tuser[dsc_pkg::USER_REJ_BIT]);
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_tally(in_tuser, in_tdata);
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("distinct_subsequence_counter test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

/* distinct_subsequence_counter.f */
rtl/dsc_pkg.sv
rtl/dsc_cell.sv
rtl/distinct_subsequence_counter.sv
rtl/dsc_checker.sv
tb/testbench.sv
